// ----- rtl/jsv_pkg.sv -----
`timescale 1ns / 1ps
// jsv_pkg: shared codes and constants for the json structure validator
// depends on nothing; imported by json_structure_validator

package jsv_pkg;

  localparam int JSV_MAX_DEPTH = 64;

  localparam int REQ_W    = 1;
  localparam int CLASS_W  = 4;
  localparam int STATUS_W = 4;
  localparam int NEST_W   = 7;
  localparam int KIND_W   = 3;

  typedef logic [REQ_W-1:0]    req_t;
  typedef logic [CLASS_W-1:0]  class_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [NEST_W-1:0]   nest_t;
  typedef logic [KIND_W-1:0]   kind_t;

  localparam req_t REQ_TOKEN = 1'd0;
  localparam req_t REQ_END   = 1'd1;

  localparam class_t TC_OPEN_OBJ  = 4'd0;
  localparam class_t TC_OPEN_ARR  = 4'd1;
  localparam class_t TC_CLOSE_OBJ = 4'd2;
  localparam class_t TC_CLOSE_ARR = 4'd3;
  localparam class_t TC_COLON     = 4'd4;
  localparam class_t TC_COMMA     = 4'd5;
  localparam class_t TC_STRING    = 4'd6;
  localparam class_t TC_SCALAR    = 4'd7;

  localparam status_t ST_OK           = 4'd0;
  localparam status_t ST_BAD_OPEN     = 4'd1;
  localparam status_t ST_BAD_CLOSE    = 4'd2;
  localparam status_t ST_TRAILING     = 4'd3;
  localparam status_t ST_BAD_COLON    = 4'd4;
  localparam status_t ST_BAD_COMMA    = 4'd5;
  localparam status_t ST_BAD_KEY      = 4'd6;
  localparam status_t ST_BAD_VALUE    = 4'd7;
  localparam status_t ST_UNEXPECTED   = 4'd8;
  localparam status_t ST_END_VALUE    = 4'd9;
  localparam status_t ST_END_COLON    = 4'd10;
  localparam status_t ST_END_OPEN     = 4'd11;
  localparam status_t ST_OVERFLOW     = 4'd12;

  localparam kind_t K_NONE     = 3'd0;
  localparam kind_t K_OPEN_OBJ = 3'd1;
  localparam kind_t K_OPEN_ARR = 3'd2;
  localparam kind_t K_CLOSE    = 3'd3;
  localparam kind_t K_COLON    = 3'd4;
  localparam kind_t K_COMMA    = 3'd5;
  localparam kind_t K_KEY      = 3'd6;
  localparam kind_t K_VALUE    = 3'd7;

endpackage

// ----- rtl/json_structure_validator.sv -----
`timescale 1ns / 1ps
// json_structure_validator: token-level json structure checker, top level
// depends on jsv_pkg
//
// Takes one classified token or end-of-document marker per cycle and returns
// one result per item, registered, in the cycle after the transaction is
// accepted; a new transaction is taken every cycle while the result side
// keeps up. The top of the brace/bracket stack sits in a flop and the entries
// beneath it sit in a MAX_DEPTH-entry memory whose registered read always
// holds the entry under the top, so a close can pop without a separate read. The
// first error is sticky until the end item, which reports the verdict and
// returns everything to the reset state. No clearing pass is needed after
// reset.

module json_structure_validator #(
  parameter int MAX_DEPTH = jsv_pkg::JSV_MAX_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  jsv_pkg::req_t     in_req_type,
  input  jsv_pkg::class_t   in_token_class,
  output logic              out_valid,
  input  logic              out_stall,
  output jsv_pkg::status_t  out_status,
  output jsv_pkg::nest_t    out_nest_depth,
  output logic              out_doc_end
);
  import jsv_pkg::*;

  localparam int DW = $clog2(MAX_DEPTH + 1);
  localparam int AW = $clog2(MAX_DEPTH);

  typedef logic [DW-1:0] depth_t;
  typedef logic [AW-1:0] addr_t;

  // control state
  depth_t  depth_r, depth_nxt;
  logic    top_r, top_nxt;
  logic    want_key_r, want_key_nxt;
  logic    want_value_r, want_value_nxt;
  logic    want_comma_r, want_comma_nxt;
  logic    want_colon_r, want_colon_nxt;
  kind_t   prior_r, prior_nxt;
  status_t err_r, err_nxt;
  logic    out_valid_r;

  // result payload
  status_t status_r, status_nxt;
  nest_t   nest_r, nest_nxt;
  logic    doc_end_r, doc_end_nxt;

  // stack memory below the top entry
  logic    mem [MAX_DEPTH];
  logic    below_r;
  logic    push;
  addr_t   wr_addr, rd_addr;
  depth_t  rd_sum;

  logic    acc, in_obj, in_arr, is_open, is_close, is_obj_cls;
  status_t tok_err;
  logic [DW+NEST_W-1:0] depth_ext;

  assign in_stall = out_valid_r && out_stall;
  assign acc      = in_valid && !in_stall;

  assign in_obj     = (depth_r != '0) && top_r;
  assign in_arr     = (depth_r != '0) && !top_r;
  assign is_open    = (in_token_class == TC_OPEN_OBJ) || (in_token_class == TC_OPEN_ARR);
  assign is_close   = (in_token_class == TC_CLOSE_OBJ) || (in_token_class == TC_CLOSE_ARR);
  assign is_obj_cls = (in_token_class == TC_OPEN_OBJ);

  always_comb begin
    depth_nxt      = depth_r;
    top_nxt        = top_r;
    want_key_nxt   = want_key_r;
    want_value_nxt = want_value_r;
    want_comma_nxt = want_comma_r;
    want_colon_nxt = want_colon_r;
    prior_nxt      = prior_r;
    err_nxt        = err_r;
    tok_err        = ST_OK;
    push           = 1'b0;

    // token evaluation
    if (is_open) begin
      if (!want_value_r) begin
        tok_err = ST_BAD_OPEN;
      end else if (depth_r == DW'(MAX_DEPTH)) begin
        tok_err = ST_OVERFLOW;
      end else begin
        push           = 1'b1;
        depth_nxt      = depth_r + 1'b1;
        top_nxt        = is_obj_cls;
        want_key_nxt   = is_obj_cls;
        want_value_nxt = !is_obj_cls;
        want_comma_nxt = 1'b0;
        want_colon_nxt = 1'b0;
        prior_nxt      = is_obj_cls ? K_OPEN_OBJ : K_OPEN_ARR;
      end
    end else if (is_close) begin
      if ((in_token_class == TC_CLOSE_OBJ && !in_obj) ||
          (in_token_class == TC_CLOSE_ARR && !in_arr)) begin
        tok_err = ST_BAD_CLOSE;
      end else if (prior_r == K_COMMA || prior_r == K_COLON || prior_r == K_KEY) begin
        tok_err = ST_TRAILING;
      end else begin
        depth_nxt      = depth_r - 1'b1;
        top_nxt        = below_r;
        want_comma_nxt = 1'b1;
        want_colon_nxt = 1'b0;
        want_key_nxt   = 1'b0;
        want_value_nxt = 1'b0;
        prior_nxt      = K_CLOSE;
      end
    end else if (in_token_class == TC_COLON) begin
      if (!want_colon_r || !in_obj) begin
        tok_err = ST_BAD_COLON;
      end else begin
        want_value_nxt = 1'b1;
        want_key_nxt   = 1'b0;
        want_comma_nxt = 1'b0;
        want_colon_nxt = 1'b0;
        prior_nxt      = K_COLON;
      end
    end else if (in_token_class == TC_COMMA) begin
      if (!want_comma_r || (!in_arr && !in_obj)) begin
        tok_err = ST_BAD_COMMA;
      end else begin
        want_comma_nxt = 1'b0;
        want_value_nxt = in_arr;
        want_key_nxt   = in_obj;
        prior_nxt      = K_COMMA;
      end
    end else if (in_obj && want_key_r) begin
      if (in_token_class != TC_STRING) begin
        tok_err = ST_BAD_KEY;
      end else begin
        want_colon_nxt = 1'b1;
        want_comma_nxt = 1'b0;
        want_value_nxt = 1'b0;
        want_key_nxt   = 1'b0;
        prior_nxt      = K_KEY;
      end
    end else if (want_value_r) begin
      if (in_token_class != TC_STRING && in_token_class != TC_SCALAR) begin
        tok_err = ST_BAD_VALUE;
      end else begin
        want_colon_nxt = 1'b0;
        want_value_nxt = 1'b0;
        want_comma_nxt = 1'b1;
        prior_nxt      = K_VALUE;
      end
    end else begin
      tok_err = ST_UNEXPECTED;
    end

    // a failing token, a latched error or an end item leaves the structure untouched
    if (err_r != ST_OK || tok_err != ST_OK || in_req_type == REQ_END) begin
      depth_nxt      = depth_r;
      top_nxt        = top_r;
      want_key_nxt   = want_key_r;
      want_value_nxt = want_value_r;
      want_comma_nxt = want_comma_r;
      want_colon_nxt = want_colon_r;
      prior_nxt      = prior_r;
      push           = 1'b0;
    end
    if (err_r == ST_OK && in_req_type == REQ_TOKEN) begin
      err_nxt = tok_err;
    end

    depth_ext   = {{NEST_W{1'b0}}, depth_nxt};
    nest_nxt    = depth_ext[NEST_W-1:0];
    status_nxt  = err_nxt;
    doc_end_nxt = 1'b0;

    if (in_req_type == REQ_END) begin
      priority if (err_r != ST_OK) begin
        status_nxt = err_r;
      end else if (want_value_r) begin
        status_nxt = ST_END_VALUE;
      end else if (want_colon_r) begin
        status_nxt = ST_END_COLON;
      end else if (depth_r != '0) begin
        status_nxt = ST_END_OPEN;
      end else begin
        status_nxt = ST_OK;
      end
      nest_nxt       = '0;
      doc_end_nxt    = 1'b1;
      depth_nxt      = '0;
      want_key_nxt   = 1'b0;
      want_value_nxt = 1'b1;
      want_comma_nxt = 1'b0;
      want_colon_nxt = 1'b0;
      prior_nxt      = K_NONE;
      err_nxt        = ST_OK;
    end
  end

  // stack memory addressing
  assign wr_addr = AW'(depth_r - 1'b1);
  assign rd_sum  = (acc ? depth_nxt : depth_r) - DW'(2);
  assign rd_addr = rd_sum[AW-1:0];

  always_ff @(posedge clk) begin
    if (acc && push && depth_r != '0) begin
      mem[wr_addr] <= top_r;
    end
    if ((acc ? depth_nxt : depth_r) >= DW'(2)) begin
      if (acc && push && depth_r != '0 && wr_addr == rd_addr) begin
        below_r <= top_r;
      end else begin
        below_r <= mem[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r      <= '0;
      top_r        <= 1'b0;
      want_key_r   <= 1'b0;
      want_value_r <= 1'b1;
      want_comma_r <= 1'b0;
      want_colon_r <= 1'b0;
      prior_r      <= K_NONE;
      err_r        <= ST_OK;
      out_valid_r  <= 1'b0;
    end else if (acc) begin
      depth_r      <= depth_nxt;
      top_r        <= top_nxt;
      want_key_r   <= want_key_nxt;
      want_value_r <= want_value_nxt;
      want_comma_r <= want_comma_nxt;
      want_colon_r <= want_colon_nxt;
      prior_r      <= prior_nxt;
      err_r        <= err_nxt;
      out_valid_r  <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      status_r  <= status_nxt;
      nest_r    <= nest_nxt;
      doc_end_r <= doc_end_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_nest_depth = nest_r;
  assign out_doc_end    = doc_end_r;

endmodule
